[hdl/stsch_pkg.sv]
// Shared types for the sorted timestep schedule table.
// Used by stsch_cell and sorted_timestep_schedule_table; no dependencies.
package stsch_pkg;

	localparam int TS_W = 63;
	localparam int ENTRY_COUNT_W = 5;

	typedef logic [TS_W-1:0] ts_t;

	// request codes
	localparam logic [1:0] REQ_ADD   = 2'd0;
	localparam logic [1:0] REQ_MATCH = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	// broadcast control from the sequencer to every cell
	typedef struct packed {
		logic ins;   // insert ts at the first slot not below it
		logic shl;   // every slot takes its right neighbor
		ts_t  ts;    // compare / insert value
	} cell_ctl_t;

endpackage

[hdl/stsch_cell.sv]
// One slot of the sorted timestep chain: holds one entry, compares it
// against the broadcast value and shifts with its neighbors.
// Depends on stsch_pkg.
module stsch_cell (
	input  logic                 clk,
	input  logic                 occ,
	input  stsch_pkg::cell_ctl_t ctl,
	input  logic                 left_lt,
	input  stsch_pkg::ts_t       left_val,
	input  stsch_pkg::ts_t       right_val,
	output stsch_pkg::ts_t       val,
	output logic                 lt,
	output logic                 eq
);

	stsch_pkg::ts_t val_q;

	assign val = val_q;
	assign lt  = occ && (val_q < ctl.ts);
	assign eq  = occ && (val_q == ctl.ts);

	always_ff @(posedge clk) begin
		if (ctl.shl) begin
			val_q <= right_val;
		end else if (ctl.ins && !lt) begin
			// first slot not below ts takes it, slots above move right
			val_q <= left_lt ? ctl.ts : left_val;
		end
	end

endmodule

[hdl/sorted_timestep_schedule_table.sv]
// Sorted, duplicate-free timestep schedule table built from a chain of
// compare-and-shift cells. Depends on stsch_pkg and stsch_cell.
//
// Usage:
//   Requests come in on req_valid/req_ready with req_type and timestep.
//   Every request gives exactly one response on rsp_valid/rsp_ready with
//   matched, dropped and entry_count (stored entries after the request).
//   Add: inserts in order, duplicates ignored, a new value on a full
//   table is not stored and flags dropped. Match: discards entries below
//   timestep, then reports whether the head equals it (head is kept).
//   Clear: empties the table. Code 3 does nothing.
// Timing:
//   For add, clear and code 3 the response is registered and shows the
//   cycle after acceptance, and a new request may be taken in that same
//   cycle. Match first registers the timestep and enters the prune state,
//   then the chain moves left one slot per cycle until the head is no
//   longer below the timestep, and then the response is registered.
// Reset: arst_n clears the entry count and the response valid; slot
//   contents are not reset and are only read below the count.
// Stall: a response waits in its register while rsp_ready is low; a new
//   request is taken only when that register is free or being emptied.
module sorted_timestep_schedule_table #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  logic [1:0]           req_type,
	input  stsch_pkg::ts_t       timestep,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output logic                 matched,
	output logic                 dropped,
	output logic [stsch_pkg::ENTRY_COUNT_W-1:0] entry_count
);

	localparam int CW = $clog2(TABLE_DEPTH + 1);

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_PRUNE = 1'b1;

	logic                  state_q;
	logic [CW-1:0]         count_q;
	stsch_pkg::ts_t        match_ts_q;

	logic                  rsp_valid_q;
	logic                  matched_q;
	logic                  dropped_q;
	logic [CW-1:0]         rsp_count_q;

	stsch_pkg::cell_ctl_t  ctl;
	stsch_pkg::ts_t        val_w [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] lt_w;
	logic [TABLE_DEPTH-1:0] eq_w;

	logic slot_free;
	logic accept;
	logic is_dup;
	logic is_full;
	logic prune_done;

	assign slot_free  = !rsp_valid_q || rsp_ready;
	assign req_ready  = (state_q == ST_IDLE) && slot_free;
	assign accept     = req_valid && req_ready;
	assign is_dup     = |eq_w;
	assign is_full    = (count_q == CW'(TABLE_DEPTH));
	// head is no longer below the match value and the response can go out
	assign prune_done = (state_q == ST_PRUNE) && !lt_w[0] && slot_free;

	always_comb begin
		ctl.ts  = (state_q == ST_PRUNE) ? match_ts_q : timestep;
		ctl.ins = accept && (req_type == stsch_pkg::REQ_ADD) && !is_dup && !is_full;
		ctl.shl = (state_q == ST_PRUNE) && lt_w[0];
	end

	// cell chain
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		logic           left_lt;
		stsch_pkg::ts_t left_val;
		stsch_pkg::ts_t right_val;

		if (i == 0) begin : g_first
			assign left_lt  = 1'b1;
			assign left_val = ctl.ts;
		end else begin : g_mid
			assign left_lt  = lt_w[i-1];
			assign left_val = val_w[i-1];
		end

		if (i == TABLE_DEPTH - 1) begin : g_last
			assign right_val = val_w[i];
		end else begin : g_inner
			assign right_val = val_w[i+1];
		end

		stsch_cell u_cell (
			.clk       (clk),
			.occ       (CW'(i) < count_q),
			.ctl       (ctl),
			.left_lt   (left_lt),
			.left_val  (left_val),
			.right_val (right_val),
			.val       (val_w[i]),
			.lt        (lt_w[i]),
			.eq        (eq_w[i])
		);
	end

	// sequencer and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req_type)
							stsch_pkg::REQ_ADD: begin
								if (ctl.ins) begin
									count_q <= count_q + CW'(1);
								end
							end
							stsch_pkg::REQ_MATCH: begin
								state_q <= ST_PRUNE;
							end
							stsch_pkg::REQ_CLEAR: begin
								count_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_PRUNE: begin
					if (ctl.shl) begin
						count_q <= count_q - CW'(1);
					end else if (prune_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			match_ts_q <= timestep;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((accept && (req_type != stsch_pkg::REQ_MATCH)) || prune_done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (prune_done) begin
			matched_q   <= eq_w[0];
			dropped_q   <= 1'b0;
			rsp_count_q <= count_q;
		end else if (accept && (req_type != stsch_pkg::REQ_MATCH)) begin
			matched_q <= 1'b0;
			dropped_q <= (req_type == stsch_pkg::REQ_ADD) && !is_dup && is_full;
			case (req_type)
				stsch_pkg::REQ_ADD:   rsp_count_q <= ctl.ins ? count_q + CW'(1) : count_q;
				stsch_pkg::REQ_CLEAR: rsp_count_q <= '0;
				default:              rsp_count_q <= count_q;
			endcase
		end
	end

	logic [CW+stsch_pkg::ENTRY_COUNT_W-1:0] count_ext;

	assign count_ext   = {{stsch_pkg::ENTRY_COUNT_W{1'b0}}, rsp_count_q};
	assign rsp_valid   = rsp_valid_q;
	assign matched     = matched_q;
	assign dropped     = dropped_q;
	assign entry_count = count_ext[stsch_pkg::ENTRY_COUNT_W-1:0];

endmodule
